### design/sound_voice_allocator_core_defines.svh
// Assertion macros for the sound voice allocator.
`ifndef SOUND_VOICE_ALLOCATOR_CORE_DEFINES_SVH
`define SOUND_VOICE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SNDVA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define SNDVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SNDVA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SNDVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### design/sndva_pkg.sv
// Shared types and constants of the sound voice allocator.
package sndva_pkg;

	localparam int NUM_CHANNELS_DEF = 32;

	localparam logic [1:0] ST_GRANTED = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_NONE    = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	localparam logic REG_CHANNELS_IN_USE = 1'b0;
	localparam logic REG_LISTENER_ENTITY = 1'b1;

	localparam logic [5:0]  CHANNELS_RESET = 6'd32;
	localparam logic [10:0] LISTENER_RESET = 11'h7ff;
	localparam logic [31:0] BEST_INIT      = 32'h7fffffff;
	localparam logic [8:0]  SUB_SINGLE_MAX = 9'd255;

	typedef struct packed {
		logic        command;
		logic [9:0]  entity;
		logic [8:0]  sub_channel;
		logic [23:0] sound_length;
		logic [31:0] now;
	} req_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] channel_index;
		logic       evicted_active;
	} rsp_word_t;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       eval;
		logic       install;
		logic       finish;
		logic [1:0] status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_stop;
		logic zero_scan;
		logic hit;
		logic busy;
		logic last;
		logic pick_vld;
	} dp_stat_t;

endpackage

### design/sndva_dp.sv
// Datapath: channel table, scan compare, pick tracking and result register.
module sndva_dp #(
	parameter int NUM_CHANNELS = sndva_pkg::NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sndva_pkg::req_word_t req,
	input  logic [5:0]           channels_in_use,
	input  logic [10:0]          listener_entity,
	input  sndva_pkg::ctrl_cmd_t cmd,
	output sndva_pkg::dp_stat_t  stat,
	output sndva_pkg::rsp_word_t rsp
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

	logic [9:0]  ent_mem [NUM_CHANNELS];
	logic [8:0]  sub_mem [NUM_CHANNELS];
	logic [31:0] end_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] active_q;

	sndva_pkg::req_word_t req_q;
	logic [CNT_W-1:0] scan_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pick_q;
	logic             pick_act_q;
	logic             pick_vld_q;
	logic [31:0]      best_q;

	logic [9:0]  rd_ent_q;
	logic [8:0]  rd_sub_q;
	logic [31:0] rd_end_q;
	logic        rd_act_q;

	sndva_pkg::rsp_word_t rsp_q;

	logic [CNT_W-1:0] scan_w;
	logic [9:0]       e_ent;
	logic [8:0]       e_sub;
	logic [31:0]      e_end;
	logic [31:0]      left;
	logic             hit;
	logic             prot;
	logic             better;

	assign scan_w = (32'(channels_in_use) > 32'(NUM_CHANNELS)) ?
		CNT_W'(NUM_CHANNELS) : CNT_W'(channels_in_use);

	// entries not installed since reset or the last clear read as zero
	assign e_ent = rd_act_q ? rd_ent_q : 10'd0;
	assign e_sub = rd_act_q ? rd_sub_q : 9'd0;
	assign e_end = rd_act_q ? rd_end_q : 32'd0;

	assign left   = e_end - req_q.now;
	assign hit    = (e_ent == req_q.entity) && (e_sub == req_q.sub_channel)
		&& (req_q.sub_channel != 9'd0);
	assign prot   = !listener_entity[10] && (e_ent == listener_entity[9:0])
		&& (req_q.entity != listener_entity[9:0]) && rd_act_q;
	assign better = $signed(left) < $signed(best_q);

	assign stat.is_stop   = req.command;
	assign stat.zero_scan = (scan_w == '0);
	assign stat.hit       = hit;
	assign stat.busy      = hit && (req_q.sub_channel > sndva_pkg::SUB_SINGLE_MAX) && rd_act_q;
	assign stat.last      = ((CNT_W'(idx_q) + CNT_W'(1)) == scan_q);
	assign stat.pick_vld  = pick_vld_q;

	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		rd_ent_q <= ent_mem[idx_q];
		rd_sub_q <= sub_mem[idx_q];
		rd_end_q <= end_mem[idx_q];
		rd_act_q <= active_q[idx_q];
		if (cmd.install) begin
			ent_mem[pick_q] <= req_q.entity;
			sub_mem[pick_q] <= req_q.sub_channel;
			end_mem[pick_q] <= req_q.now + 32'(req_q.sound_length);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			pick_vld_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (cmd.clear) begin
				active_q <= '0;
			end else if (cmd.install) begin
				active_q[pick_q] <= 1'b1;
			end
			if (cmd.load) begin
				pick_vld_q <= 1'b0;
				idx_q      <= '0;
			end else if (cmd.eval) begin
				idx_q <= idx_q + IDX_W'(1);
				if ((hit && !stat.busy) || (!hit && !prot && better)) begin
					pick_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req;
			scan_q <= scan_w;
			best_q <= sndva_pkg::BEST_INIT;
		end else if (cmd.eval) begin
			if (hit) begin
				pick_q     <= idx_q;
				pick_act_q <= rd_act_q;
			end else if (!prot && better) begin
				best_q     <= left;
				pick_q     <= idx_q;
				pick_act_q <= rd_act_q;
			end
		end
		if (cmd.finish) begin
			rsp_q.status <= cmd.status;
			if (cmd.status == sndva_pkg::ST_GRANTED) begin
				rsp_q.channel_index  <= 5'(pick_q);
				rsp_q.evicted_active <= pick_act_q;
			end else begin
				rsp_q.channel_index  <= 5'd0;
				rsp_q.evicted_active <= 1'b0;
			end
		end
	end

endmodule

### design/sndva_ctrl.sv
// Controller: sequences accept, channel scan, install and result handoff.
`include "sound_voice_allocator_core_defines.svh"

module sndva_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  sndva_pkg::dp_stat_t  stat,
	output sndva_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EV   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] status_q;
	logic [1:0] status_d;
	logic       rsp_valid_q;
	logic       accept;
	logic       out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		status_d    = status_q;
		cmd.load    = 1'b0;
		cmd.clear   = 1'b0;
		cmd.eval    = 1'b0;
		cmd.install = 1'b0;
		cmd.finish  = 1'b0;
		cmd.status  = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (stat.is_stop) begin
						cmd.clear = 1'b1;
						status_d  = sndva_pkg::ST_CLEARED;
						state_d   = S_DONE;
					end else if (stat.zero_scan) begin
						status_d = sndva_pkg::ST_NONE;
						state_d  = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				state_d = S_EV;
			end
			S_EV: begin
				cmd.eval = 1'b1;
				if (stat.busy) begin
					status_d = sndva_pkg::ST_BUSY;
					state_d  = S_DONE;
				end else if (stat.hit || stat.last) begin
					state_d = S_WR;
				end else begin
					state_d = S_RD;
				end
			end
			S_WR: begin
				cmd.install = stat.pick_vld;
				status_d    = stat.pick_vld ? sndva_pkg::ST_GRANTED : sndva_pkg::ST_NONE;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= sndva_pkg::ST_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`SNDVA_ASSERT_NEXT(a_stop_clears, clk, arst_n, accept && stat.is_stop, state_q == S_DONE && status_q == sndva_pkg::ST_CLEARED, "stop word did not end in cleared status")
	`SNDVA_ASSERT_NEXT(a_busy_refuse, clk, arst_n, state_q == S_EV && stat.busy, state_q == S_DONE && status_q == sndva_pkg::ST_BUSY, "busy single instance not refused")
	`SNDVA_ASSERT_NEXT(a_no_pick, clk, arst_n, state_q == S_WR && !stat.pick_vld, status_q == sndva_pkg::ST_NONE, "grant without a picked channel")
	`SNDVA_ASSERT_IMPL(a_finish_free, clk, arst_n, cmd.finish, !rsp_valid_q || rsp_ready, "result overwritten before it was taken")

endmodule

### design/sound_voice_allocator_core.sv
// Top level of the sound voice allocator: register port, controller and datapath.
//
// channel  handshake                    payload
// req      req_valid / req_ready        sndva_pkg::req_word_t
// rsp      rsp_valid / rsp_ready        sndva_pkg::rsp_word_t
// cfg      psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A start word scans up to min(channels_in_use, NUM_CHANNELS) table entries, reading each
// in S_RD and comparing in S_EV; S_WR installs any pick, S_DONE hands off the result.
// Stop words and a zero scan count skip the scan; a matching owner ends it early.
// After reset the table is empty; a stop word clears it as it is accepted.
// A stalled result is held and the next word is taken once it is registered.
module sound_voice_allocator_core #(
	parameter int NUM_CHANNELS = sndva_pkg::NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  sndva_pkg::req_word_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output sndva_pkg::rsp_word_t rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [5:0]  channels_in_use_q;
	logic [10:0] listener_entity_q;
	logic        cfg_wr;

	sndva_pkg::ctrl_cmd_t cmd;
	sndva_pkg::dp_stat_t  stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_in_use_q <= sndva_pkg::CHANNELS_RESET;
			listener_entity_q <= sndva_pkg::LISTENER_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				sndva_pkg::REG_CHANNELS_IN_USE: channels_in_use_q <= pwdata[5:0];
				sndva_pkg::REG_LISTENER_ENTITY: listener_entity_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			sndva_pkg::REG_CHANNELS_IN_USE: prdata = {26'd0, channels_in_use_q};
			sndva_pkg::REG_LISTENER_ENTITY: prdata = {{21{listener_entity_q[10]}},
				listener_entity_q};
			default: prdata = 32'd0;
		endcase
	end

	sndva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sndva_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.channels_in_use (channels_in_use_q),
		.listener_entity (listener_entity_q),
		.cmd             (cmd),
		.stat            (stat),
		.rsp             (rsp)
	);

endmodule
